/* sv/shsd_pkg.sv */
// Package: item types, register map and half-step tables for the stepper driver.
`timescale 1ns / 1ps
`default_nettype none
package shsd_pkg;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_REV  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_START_RELOAD  = 2'd0,
    REG_MIN_RELOAD    = 2'd1,
    REG_RAMP_INTERVAL = 2'd2,
    REG_RUN_TICKS     = 2'd3
  } reg_idx_e;

  localparam logic [7:0]  START_RELOAD_RST  = 8'd149;
  localparam logic [7:0]  MIN_RELOAD_RST    = 8'd59;
  localparam logic [15:0] RAMP_INTERVAL_RST = 16'd100;
  localparam logic [15:0] RUN_TICKS_RST     = 16'd8000;

  typedef struct packed {
    logic kind;
    logic switch_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] coils;
    logic [1:0] direction;
    logic       curtain_state;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  start_reload;
    logic [7:0]  min_reload;
    logic [15:0] ramp_interval;
    logic [15:0] run_ticks;
  } cfg_t;

  function automatic logic [3:0] fwd_pattern(input logic [2:0] ph);
    logic [3:0] p;
    case (ph)
      3'd0: p = 4'h1;
      3'd1: p = 4'h3;
      3'd2: p = 4'h2;
      3'd3: p = 4'h6;
      3'd4: p = 4'h4;
      3'd5: p = 4'hC;
      3'd6: p = 4'h8;
      3'd7: p = 4'h9;
      default: p = 4'h0;
    endcase
    return p;
  endfunction

  function automatic logic [3:0] rev_pattern(input logic [2:0] ph);
    logic [3:0] p;
    case (ph)
      3'd0: p = 4'h8;
      3'd1: p = 4'hC;
      3'd2: p = 4'h4;
      3'd3: p = 4'h6;
      3'd4: p = 4'h2;
      3'd5: p = 4'h3;
      3'd6: p = 4'h1;
      3'd7: p = 4'h9;
      default: p = 4'h0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

/* sv/shsd_core.sv */
// Stepper motion state: period timing, ramp, step count, phase and coil drive.
`timescale 1ns / 1ps
`default_nettype none
module shsd_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  take_i,
  input  shsd_pkg::in_item_t   item_i,
  input  shsd_pkg::cfg_t       cfg_i,
  output shsd_pkg::out_item_t  res_o
);
  import shsd_pkg::*;

  logic [7:0]  period_q, period_d;
  logic [7:0]  reload_q, reload_d;
  logic [15:0] steps_q, steps_d;
  logic [2:0]  phase_q, phase_d;
  mode_e       mode_q, mode_d;
  logic        flag_q, flag_d;
  logic [3:0]  coil_q, coil_d;

  logic [15:0] steps_inc;
  logic [15:0] steps_ramp;
  logic        ramp_hit;

  assign steps_inc  = steps_q + 16'd1;
  assign ramp_hit   = (steps_inc >= cfg_i.ramp_interval) && (reload_q > cfg_i.min_reload);
  assign steps_ramp = ramp_hit ? 16'd0 : steps_inc;

  always_comb begin
    period_d = period_q;
    reload_d = reload_q;
    steps_d  = steps_q;
    phase_d  = phase_q;
    mode_d   = mode_q;
    flag_d   = flag_q;
    coil_d   = coil_q;
    if (item_i.kind) begin
      if (!item_i.switch_value && flag_q) begin
        flag_d   = 1'b0;
        mode_d   = MODE_FWD;
        steps_d  = '0;
        reload_d = cfg_i.start_reload;
        period_d = '0;
      end else if (item_i.switch_value && !flag_q) begin
        flag_d   = 1'b1;
        mode_d   = MODE_REV;
        steps_d  = '0;
        reload_d = cfg_i.start_reload;
        period_d = '0;
      end
    end else if (mode_q == MODE_FWD || mode_q == MODE_REV) begin
      if (period_q >= reload_q) begin
        // end of step period
        period_d = '0;
        steps_d  = steps_ramp;
        if (ramp_hit) begin
          reload_d = reload_q - 8'd1;
        end
        if (steps_ramp >= cfg_i.run_ticks) begin
          mode_d = MODE_STOP;
          coil_d = '0;
        end else begin
          coil_d  = (mode_q == MODE_FWD) ? fwd_pattern(phase_q) : rev_pattern(phase_q);
          phase_d = phase_q + 3'd1;
        end
      end else begin
        period_d = period_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      reload_q <= START_RELOAD_RST;
      steps_q  <= '0;
      phase_q  <= '0;
      mode_q   <= MODE_STOP;
      flag_q   <= 1'b0;
      coil_q   <= '0;
    end else if (take_i) begin
      period_q <= period_d;
      reload_q <= reload_d;
      steps_q  <= steps_d;
      phase_q  <= phase_d;
      mode_q   <= mode_d;
      flag_q   <= flag_d;
      coil_q   <= coil_d;
    end
  end

  assign res_o.coils         = coil_d;
  assign res_o.direction     = mode_d;
  assign res_o.curtain_state = flag_d;

endmodule
`default_nettype wire

/* sv/stepper_half_step_ramp_driver.sv */
// Top level: config registers, motion core and output register with skid stage.
// Results are registered in the output register, or in the skid stage under a stall.
// Throughput: one item per cycle unless stalled; motion state updated in a single pass.
// in_stall_o is high while the skid stage holds an item, from the cycle after an item
// is taken under an output stall until the output register drains.
// Reset: asynchronous, active low; motion stopped, coils off, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none
module stepper_half_step_ramp_driver (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  shsd_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output shsd_pkg::out_item_t  out_item_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire  [1:0]           cfg_index_i,
  input  wire  [15:0]          cfg_data_i
);
  import shsd_pkg::*;

  cfg_t      cfg_q;
  out_item_t res;
  out_item_t out_item_q, skid_item_q;
  logic      out_valid_q, skid_valid_q;
  logic      in_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_reload  <= START_RELOAD_RST;
      cfg_q.min_reload    <= MIN_RELOAD_RST;
      cfg_q.ramp_interval <= RAMP_INTERVAL_RST;
      cfg_q.run_ticks     <= RUN_TICKS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_START_RELOAD:  cfg_q.start_reload  <= cfg_data_i[7:0];
        REG_MIN_RELOAD:    cfg_q.min_reload    <= cfg_data_i[7:0];
        REG_RAMP_INTERVAL: cfg_q.ramp_interval <= cfg_data_i;
        REG_RUN_TICKS:     cfg_q.run_ticks     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_take    = in_valid_i && !skid_valid_q;

  shsd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (in_take),
    .item_i (in_item_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_take;
      end
    end else if (in_take) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_item_q <= skid_valid_q ? skid_item_q : res;
    end else if (in_take) begin
      skid_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds an item while output register is empty");

  a_stopped_coils_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.direction == MODE_STOP) |-> (out_item_q.coils == 4'h0))
    else $error("coils driven while motion stopped");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && in_take) |=> skid_valid_q)
    else $error("item accepted under output stall was not kept");

endmodule
`default_nettype wire

/* tb/tb_stepper_half_step_ramp_driver.sv */
// Self-checking testbench for the half-step stepper driver with acceleration ramp.
`timescale 1ns / 1ps
module tb_stepper_half_step_ramp_driver;
  import shsd_pkg::*;

  localparam int IDLE_LIMIT      = 4000;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int NUM_PHASES      = 9;
  localparam int MAX_PRINTS      = 100;

  localparam logic [3:0] OPEN_SEQ  [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
  localparam logic [3:0] CLOSE_SEQ [8] = '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    in_item_t  item;
    logic      typed;
    out_item_t want;
    cfg_t      cfg;
  } row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  in_item_t    in_item_i   = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;

  stepper_half_step_ramp_driver u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // motor model state
  cfg_t       motor_cfg;
  logic [7:0] tick_cnt;
  logic [7:0] reload_now;
  logic [15:0] step_cnt;
  logic [2:0] phase_idx;
  mode_e      motion;
  logic       curtain;
  logic [3:0] coil_drive;

  out_item_t  pending_drive[$];
  int         mismatches = 0;
  logic       gappy      = 1'b0;
  logic       stall_on   = 1'b0;

  function automatic void start_motion(mode_e dir);
    step_cnt   = '0;
    reload_now = motor_cfg.start_reload;
    tick_cnt   = '0;
    motion     = dir;
  endfunction

  function automatic out_item_t predict_drive(in_item_t it);
    if (it.kind) begin
      if (!it.switch_value && curtain) begin
        curtain = 1'b0;
        start_motion(MODE_FWD);
      end else if (it.switch_value && !curtain) begin
        curtain = 1'b1;
        start_motion(MODE_REV);
      end
    end else if (motion != MODE_STOP) begin
      if (tick_cnt >= reload_now) begin
        tick_cnt = '0;
        step_cnt = step_cnt + 16'd1;
        if (step_cnt >= motor_cfg.ramp_interval && reload_now > motor_cfg.min_reload) begin
          step_cnt   = '0;
          reload_now = reload_now - 8'd1;
        end
        if (step_cnt >= motor_cfg.run_ticks) begin
          motion     = MODE_STOP;
          coil_drive = '0;
        end else begin
          coil_drive = (motion == MODE_FWD) ? OPEN_SEQ[phase_idx] : CLOSE_SEQ[phase_idx];
          phase_idx  = phase_idx + 3'd1;
        end
      end else begin
        tick_cnt = tick_cnt + 8'd1;
      end
    end
    return '{coils: coil_drive, direction: motion, curtain_state: curtain};
  endfunction

  function automatic cfg_t mk_cfg(int s, int m, int r, int t);
    return '{start_reload: 8'(s), min_reload: 8'(m), ramp_interval: 16'(r),
             run_ticks: 16'(t)};
  endfunction

  function automatic row_t item_row(logic k, logic sw, logic typed, logic [3:0] c,
                                    mode_e d, logic cs);
    return '{kind: ROW_ITEM, item: '{kind: k, switch_value: sw}, typed: typed,
             want: '{coils: c, direction: d, curtain_state: cs}, cfg: '0};
  endfunction

  function automatic row_t cfg_row(cfg_t c);
    return '{kind: ROW_CFG, item: '0, typed: 1'b0, want: '0, cfg: c};
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < MAX_PRINTS)
      $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(in_item_t it, logic typed, out_item_t want);
    out_item_t pred;
    if (gappy && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = predict_drive(it);
    pending_drive.push_back(typed ? want : pred);
  endtask

  // registers are only written with no item in flight
  task automatic program_cfg(cfg_t c, logic [7:0] junk);
    in_valid_i <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_idx_e'(i);
      case (reg_idx_e'(i))
        REG_START_RELOAD:  cfg_data_i <= {junk, c.start_reload};
        REG_MIN_RELOAD:    cfg_data_i <= {~junk, c.min_reload};
        REG_RAMP_INTERVAL: cfg_data_i <= c.ramp_interval;
        default:           cfg_data_i <= c.run_ticks;
      endcase
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    motor_cfg = c;
  endtask

  // output stall in bursts
  int   stall_left = 0;
  logic stalling   = 1'b0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stalling   = stall_on && !stalling && ($urandom_range(0, 2) == 0);
      stall_left = stalling ? $urandom_range(1, 13) : $urandom_range(1, 30);
    end
    stall_left--;
    out_stall_i <= stalling && stall_on;
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_drive.size() == 0) begin
        report_mismatch("unexpected item", out_item_o, 0);
      end else begin
        want = pending_drive.pop_front();
        if (out_item_o.coils != want.coils)
          report_mismatch("coils", out_item_o.coils, want.coils);
        if (out_item_o.direction != want.direction)
          report_mismatch("direction", out_item_o.direction, want.direction);
        if (out_item_o.curtain_state != want.curtain_state)
          report_mismatch("curtain_state", out_item_o.curtain_state, want.curtain_state);
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    row_t       dir_rows[$];
    row_t       r;
    cfg_t       c;
    logic [7:0] junk;
    in_item_t   it;
    int         s;

    motor_cfg  = '{start_reload: START_RELOAD_RST, min_reload: MIN_RELOAD_RST,
                   ramp_interval: RAMP_INTERVAL_RST, run_ticks: RUN_TICKS_RST};
    tick_cnt   = '0;
    reload_now = START_RELOAD_RST;
    step_cnt   = '0;
    phase_idx  = '0;
    motion     = MODE_STOP;
    curtain    = 1'b0;
    coil_drive = '0;

    // tick while stopped, redundant open, close, redundant close, tick, then reopen
    dir_rows.push_back(item_row(1'b0, 1'b0, 1'b1, 4'h0, MODE_STOP, 1'b0));
    dir_rows.push_back(item_row(1'b1, 1'b0, 1'b1, 4'h0, MODE_STOP, 1'b0));
    dir_rows.push_back(item_row(1'b1, 1'b1, 1'b1, 4'h0, MODE_REV, 1'b1));
    dir_rows.push_back(item_row(1'b1, 1'b1, 1'b1, 4'h0, MODE_REV, 1'b1));
    dir_rows.push_back(item_row(1'b0, 1'b1, 1'b1, 4'h0, MODE_REV, 1'b1));
    dir_rows.push_back(item_row(1'b1, 1'b0, 1'b1, 4'h0, MODE_FWD, 1'b0));
    // fast ramp to zero reload, short run
    dir_rows.push_back(cfg_row(mk_cfg(1, 0, 1, 2)));
    dir_rows.push_back(item_row(1'b1, 1'b1, 1'b1, 4'h0, MODE_REV, 1'b1));
    repeat (4) dir_rows.push_back(item_row(1'b0, 1'b0, 1'b0, 4'h0, MODE_STOP, 1'b0));
    dir_rows.push_back(item_row(1'b0, 1'b0, 1'b1, 4'h0, MODE_STOP, 1'b1));
    dir_rows.push_back(item_row(1'b1, 1'b0, 1'b1, 4'h0, MODE_FWD, 1'b0));
    repeat (3) dir_rows.push_back(item_row(1'b0, 1'b1, 1'b0, 4'h0, MODE_STOP, 1'b0));
    // zero ramp interval and zero run length
    dir_rows.push_back(cfg_row(mk_cfg(0, 0, 0, 0)));
    dir_rows.push_back(item_row(1'b1, 1'b1, 1'b0, 4'h0, MODE_STOP, 1'b0));
    dir_rows.push_back(item_row(1'b0, 1'b0, 1'b0, 4'h0, MODE_STOP, 1'b0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_CFG) program_cfg(r.cfg, 8'h00);
      else send_item(r.item, r.typed, r.want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      junk = 8'($urandom_range(0, 255));
      case (p)
        0: begin
          c    = mk_cfg(255, 0, 65535, 65535);
          junk = 8'hFF;
        end
        1: c = mk_cfg(0, 0, 1, 1);
        2: c = mk_cfg(4, 1, 0, 3);
        3: c = mk_cfg(3, 255, 2, 0);
        4: c = mk_cfg(5, 2, 3, 9);
        default: begin
          s = $urandom_range(0, 6);
          c = mk_cfg(s, $urandom_range(0, s), $urandom_range(1, 4), $urandom_range(1, 12));
        end
      endcase
      program_cfg(c, junk);
      gappy    = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      stall_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      repeat (ITEMS_PER_PHASE) begin
        it.kind         = ($urandom_range(0, 29) == 0);
        it.switch_value = 1'($urandom_range(0, 1));
        send_item(it, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
